### hw/rtl/lltm_pkg.sv
// Package for the LCD line timing and mode unit: widths, timing constants,
// mode codes and the tick and result structs shared between the modules.
// No dependencies.
`default_nettype none

package lltm_pkg;

    localparam int unsigned CYCLE_W = 9;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned SUM_W   = 10;

    localparam logic [SUM_W-1:0]   LINE_CYCLES = 10'd456;
    localparam logic [LINE_W-1:0]  LAST_LINE   = 8'd153;
    localparam logic [LINE_W-1:0]  VBLANK_LINE = 8'd144;
    localparam logic [CYCLE_W-1:0] SCAN_END    = 9'd80;
    localparam logic [CYCLE_W-1:0] DRAW_END    = 9'd252;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_DRAW   = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        logic [7:0]        elapsed_cycles;
        logic              lcd_on;
        logic [7:0]        compare_line;
    } tick_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        lcd_mode_t         lcd_mode;
        logic              line_match;
        logic              vblank_pulse;
        logic              render_request;
        logic [LINE_W-1:0] render_line;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/lltm_input_stage.sv
// Input register of the LCD line timing unit: captures one tick transaction
// and holds it until the timing core takes it. Depends on lltm_pkg.
`default_nettype none

module lltm_input_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire lltm_pkg::tick_t tick_in,
    input  wire logic            take,
    output logic                 tick_valid,
    output lltm_pkg::tick_t      tick_out
);

    logic            valid_reg;
    logic            valid_next;
    lltm_pkg::tick_t tick_reg;
    logic            load;

    // Accept when empty or when the held tick moves on this cycle
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tick_reg <= tick_in;
        end
    end

    assign tick_valid = valid_reg;
    assign tick_out   = tick_reg;

endmodule

`default_nettype wire

### hw/rtl/lltm_timing_core.sv
// Timing core of the LCD line timing unit: cycle and line counters, match
// hold, and the result of one tick. Depends on lltm_pkg.
`default_nettype none

module lltm_timing_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            commit,
    input  wire lltm_pkg::tick_t tick,
    output lltm_pkg::result_t    result
);

    logic [lltm_pkg::CYCLE_W-1:0] cycle_reg;
    logic [lltm_pkg::CYCLE_W-1:0] cycle_next;
    logic [lltm_pkg::LINE_W-1:0]  line_reg;
    logic [lltm_pkg::LINE_W-1:0]  line_next;
    logic                         match_reg;
    logic                         match_next;
    logic [lltm_pkg::SUM_W-1:0]   sum;
    logic [lltm_pkg::SUM_W-1:0]   sum_wrapped;
    logic                         wrap;
    logic [lltm_pkg::LINE_W-1:0]  line_inc;

    // Add the elapsed cycles and detect the end of the line
    assign sum         = {1'b0, cycle_reg} + {2'b00, tick.elapsed_cycles};
    assign sum_wrapped = sum - lltm_pkg::LINE_CYCLES;
    assign wrap        = sum >= lltm_pkg::LINE_CYCLES;
    assign line_inc    = line_reg + 8'd1;

    always_comb
    begin
        cycle_next            = '0;
        line_next             = '0;
        match_next            = match_reg;
        result.line_number    = '0;
        result.lcd_mode       = lltm_pkg::MODE_HBLANK;
        result.line_match     = match_reg;
        result.vblank_pulse   = 1'b0;
        result.render_request = 1'b0;
        result.render_line    = '0;
        if (tick.lcd_on)
        begin
            // Advance the counters
            if (wrap)
            begin
                cycle_next = sum_wrapped[lltm_pkg::CYCLE_W-1:0];
                if (line_reg < lltm_pkg::VBLANK_LINE)
                begin
                    result.render_request = 1'b1;
                    result.render_line    = line_reg;
                end
                result.vblank_pulse = (line_inc == lltm_pkg::VBLANK_LINE);
                line_next = (line_inc > lltm_pkg::LAST_LINE) ? '0 : line_inc;
            end
            else
            begin
                cycle_next = sum[lltm_pkg::CYCLE_W-1:0];
                line_next  = line_reg;
            end

            // Pick the mode from the new position
            if (line_next >= lltm_pkg::VBLANK_LINE)
            begin
                result.lcd_mode = lltm_pkg::MODE_VBLANK;
            end
            else if (cycle_next < lltm_pkg::SCAN_END)
            begin
                result.lcd_mode = lltm_pkg::MODE_SCAN;
            end
            else if (cycle_next < lltm_pkg::DRAW_END)
            begin
                result.lcd_mode = lltm_pkg::MODE_DRAW;
            end
            else
            begin
                result.lcd_mode = lltm_pkg::MODE_HBLANK;
            end

            match_next         = (line_next == tick.compare_line);
            result.line_number = line_next;
            result.line_match  = match_next;
        end
    end

    // Update the timing state once per committed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg <= '0;
            line_reg  <= '0;
            match_reg <= 1'b0;
        end
        else if (commit)
        begin
            cycle_reg <= cycle_next;
            line_reg  <= line_next;
            match_reg <= match_next;
        end
    end

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= lltm_pkg::LAST_LINE)
        else $error("line counter beyond last line");

    a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cycle_reg} < lltm_pkg::LINE_CYCLES)
        else $error("cycle counter beyond line length");

    a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
        result.vblank_pulse |-> (result.line_number == lltm_pkg::VBLANK_LINE
                                 && result.lcd_mode == lltm_pkg::MODE_VBLANK))
        else $error("vertical blank pulse off line 144");

    a_render_visible: assert property (@(posedge clk) disable iff (!rst_n)
        result.render_request |-> (result.render_line < lltm_pkg::VBLANK_LINE
                                   && line_next == result.render_line + 8'd1))
        else $error("render request for a line that did not just finish");

endmodule

`default_nettype wire

### hw/rtl/lltm_output_stage.sv
// Result register of the LCD line timing unit: holds one result transaction
// until the receiver takes it. Depends on lltm_pkg.
`default_nettype none

module lltm_output_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    output logic                   res_ready,
    input  wire lltm_pkg::result_t res_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output lltm_pkg::result_t      res_out
);

    logic              valid_reg;
    logic              valid_next;
    lltm_pkg::result_t res_reg;
    logic              load;

    // Take a new result when empty or when the held one leaves this cycle
    assign res_ready = !valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

### hw/rtl/lcd_line_timing_and_mode_unit.sv
// Top level of the LCD line timing and mode unit: input register, timing
// core and result register. Depends on lltm_pkg and the three lltm modules.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------
//   in      | in_valid / in_stall | elapsed_cycles, lcd_on, compare_line
//   out     | out_valid/out_stall | line_number, lcd_mode, line_match,
//           |                     | vblank_pulse, render_request, render_line
//
// One tick per cycle while the output does not stall; a tick is held in the
// input register, and its result is registered in the result register. The
// rate is set by the combinational add, compare and wrap in the timing core.
// Reset clears the cycle counter, line counter and match flag, and empties
// both registers. A stalled output holds the result register; a full input
// register then stalls the input side.
`default_nettype none

module lcd_line_timing_and_mode_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] elapsed_cycles,
    input  wire logic       lcd_on,
    input  wire logic [7:0] compare_line,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      line_number,
    output logic [1:0]      lcd_mode,
    output logic            line_match,
    output logic            vblank_pulse,
    output logic            render_request,
    output logic [7:0]      render_line
);

    lltm_pkg::tick_t   tick_in;
    lltm_pkg::tick_t   tick_held;
    lltm_pkg::result_t res_core;
    lltm_pkg::result_t res_out;
    logic              tick_valid;
    logic              res_ready;
    logic              commit;

    assign tick_in.elapsed_cycles = elapsed_cycles;
    assign tick_in.lcd_on         = lcd_on;
    assign tick_in.compare_line   = compare_line;

    // Move a tick into the result register when there is room
    assign commit = tick_valid && res_ready;

    lltm_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .tick_in    (tick_in),
        .take       (commit),
        .tick_valid (tick_valid),
        .tick_out   (tick_held)
    );

    lltm_timing_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .tick   (tick_held),
        .result (res_core)
    );

    lltm_output_stage u_output
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (tick_valid),
        .res_ready (res_ready),
        .res_in    (res_core),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign line_number    = res_out.line_number;
    assign lcd_mode       = res_out.lcd_mode;
    assign line_match     = res_out.line_match;
    assign vblank_pulse   = res_out.vblank_pulse;
    assign render_request = res_out.render_request;
    assign render_line    = res_out.render_line;

endmodule

`default_nettype wire

### dv/lcd_timing_checker.sv
// Checker for the LCD line timing and mode unit: watches both channels, keeps
// its own line and cycle timing, and compares every result transaction.
// Depends on lltm_pkg for the timing constants, widths and mode codes.

module lcd_timing_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] elapsed_cycles,
    input  wire logic       lcd_on,
    input  wire logic [7:0] compare_line,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] line_number,
    input  wire logic [1:0] lcd_mode,
    input  wire logic       line_match,
    input  wire logic       vblank_pulse,
    input  wire logic       render_request,
    input  wire logic [7:0] render_line,
    output int              fail_count,
    output int              pending,
    output logic [7:0]      line_hint,
    output int              frames_seen,
    output int              renders_seen,
    output int              results_checked
);

    // Predicted timing state, mirrors the block after each accepted tick
    logic [lltm_pkg::CYCLE_W-1:0] cycle_pos;
    logic [lltm_pkg::LINE_W-1:0]  line_pos;
    logic                         match_flag;

    lltm_pkg::result_t expected_q[$];
    lltm_pkg::result_t predicted;

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        line_hint       = '0;
        frames_seen     = 0;
        renders_seen    = 0;
        results_checked = 0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Advance the line timing by one tick and build the expected result
    task automatic advance_timing(input logic [7:0] elapsed, input logic on,
                                  input logic [7:0] cmp, output lltm_pkg::result_t r);
        logic [lltm_pkg::SUM_W-1:0] sum;
        r = '0;
        // Display off: clear timing, hold the match flag as last reported
        if (!on)
        begin
            cycle_pos    = '0;
            line_pos     = '0;
            r.lcd_mode   = lltm_pkg::MODE_HBLANK;
            r.line_match = match_flag;
            return;
        end
        sum = {1'b0, cycle_pos} + {2'b00, elapsed};
        // At most one line end per tick, since elapsed stays below a line
        if (sum >= lltm_pkg::LINE_CYCLES)
        begin
            sum = sum - lltm_pkg::LINE_CYCLES;
            if (line_pos < lltm_pkg::VBLANK_LINE)
            begin
                r.render_request = 1'b1;
                r.render_line    = line_pos;
            end
            // Wrap from the last line to line 0 gives no pulse
            if (line_pos == lltm_pkg::LAST_LINE)
                line_pos = '0;
            else
                line_pos = line_pos + 8'd1;
            if (line_pos == lltm_pkg::VBLANK_LINE)
                r.vblank_pulse = 1'b1;
        end
        cycle_pos = sum[lltm_pkg::CYCLE_W-1:0];
        if (line_pos >= lltm_pkg::VBLANK_LINE)
            r.lcd_mode = lltm_pkg::MODE_VBLANK;
        else if (cycle_pos < lltm_pkg::SCAN_END)
            r.lcd_mode = lltm_pkg::MODE_SCAN;
        else if (cycle_pos < lltm_pkg::DRAW_END)
            r.lcd_mode = lltm_pkg::MODE_DRAW;
        else
            r.lcd_mode = lltm_pkg::MODE_HBLANK;
        match_flag    = (line_pos == cmp);
        r.line_number = line_pos;
        r.line_match  = match_flag;
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic check_result();
        lltm_pkg::result_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("result with nothing expected, line_number", line_number, 0);
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (line_number !== want.line_number)
            report_mismatch("line_number", line_number, want.line_number);
        if (lcd_mode !== want.lcd_mode)
            report_mismatch("lcd_mode", lcd_mode, want.lcd_mode);
        if (line_match !== want.line_match)
            report_mismatch("line_match", line_match, want.line_match);
        if (vblank_pulse !== want.vblank_pulse)
            report_mismatch("vblank_pulse", vblank_pulse, want.vblank_pulse);
        if (render_request !== want.render_request)
            report_mismatch("render_request", render_request, want.render_request);
        if (render_line !== want.render_line)
            report_mismatch("render_line", render_line, want.render_line);
    endtask

    // Check results first, then queue the prediction for a new tick
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_pos  = '0;
            line_pos   = '0;
            match_flag = 1'b0;
            expected_q.delete();
            pending   <= 0;
            line_hint <= '0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
            begin
                advance_timing(elapsed_cycles, lcd_on, compare_line, predicted);
                expected_q.push_back(predicted);
                if (predicted.vblank_pulse)
                    frames_seen++;
                if (predicted.render_request)
                    renders_seen++;
            end
            pending   <= expected_q.size();
            line_hint <= line_pos;
        end
    end

endmodule

### dv/lcd_line_timing_and_mode_unit_tb.sv
// Testbench top for the LCD line timing and mode unit: clock, reset, tick
// stimulus, output stalls, watchdog and verdict. Depends on lltm_pkg, the
// unit's RTL and lcd_timing_checker.

module lcd_line_timing_and_mode_unit_tb;

    localparam int RANDOM_PER_PHASE = 150;
    localparam int EXTRA_LIMIT      = 45;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 8;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic [7:0] elapsed_cycles = '0;
    logic       lcd_on         = 1'b0;
    logic [7:0] compare_line   = '0;
    logic       out_stall      = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [7:0] line_number;
    logic [1:0] lcd_mode;
    logic       line_match;
    logic       vblank_pulse;
    logic       render_request;
    logic [7:0] render_line;

    int         fail_count;
    int         pending;
    logic [7:0] line_hint;
    int         frames_seen;
    int         renders_seen;
    int         results_checked;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int          ticks_sent = 0;
    int          idle_cycles = 0;

    // Sender idle and receiver stall percentages for each random phase
    int unsigned idle_by_phase [4] = '{0, 69, 0, 20};
    int unsigned stall_by_phase[4] = '{0, 0, 69, 20};

    always #5 clk = ~clk;

    lcd_line_timing_and_mode_unit DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .elapsed_cycles (elapsed_cycles),
        .lcd_on         (lcd_on),
        .compare_line   (compare_line),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .line_number    (line_number),
        .lcd_mode       (lcd_mode),
        .line_match     (line_match),
        .vblank_pulse   (vblank_pulse),
        .render_request (render_request),
        .render_line    (render_line)
    );

    lcd_timing_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .elapsed_cycles  (elapsed_cycles),
        .lcd_on          (lcd_on),
        .compare_line    (compare_line),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .line_number     (line_number),
        .lcd_mode        (lcd_mode),
        .line_match      (line_match),
        .vblank_pulse    (vblank_pulse),
        .render_request  (render_request),
        .render_line     (render_line),
        .fail_count      (fail_count),
        .pending         (pending),
        .line_hint       (line_hint),
        .frames_seen     (frames_seen),
        .renders_seen    (renders_seen),
        .results_checked (results_checked)
    );

    // Stall the result side at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Drop the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lcd_line_timing_and_mode_unit verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one tick, with a random idle gap first, and hold it until taken
    task automatic send_tick(input logic [7:0] elapsed, input logic on,
                             input logic [7:0] cmp);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        elapsed_cycles <= elapsed;
        lcd_on         <= on;
        compare_line   <= cmp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
    endtask

    // Mostly long ticks with the display on, so frames complete; compare
    // values often aim at the current or next line to hit matches
    task automatic send_random_tick();
        logic [7:0] elapsed;
        logic [7:0] cmp;
        logic       on;
        if ($urandom_range(99) < 85)
            elapsed = 8'($urandom_range(255, 200));
        else
            elapsed = 8'($urandom_range(255));
        on = ($urandom_range(249) != 0);
        case ($urandom_range(4))
            0, 1:    cmp = 8'($urandom_range(255));
            2:       cmp = line_hint;
            default: cmp = line_hint + 8'd1;
        endcase
        send_tick(elapsed, on, cmp);
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int extra;
        extra = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mode boundaries, line end, large compare, display off
        send_tick(8'd0,   1'b1, 8'd0);
        send_tick(8'd79,  1'b1, 8'd1);
        send_tick(8'd1,   1'b1, 8'd0);
        send_tick(8'd171, 1'b1, 8'd0);
        send_tick(8'd1,   1'b1, 8'd0);
        send_tick(8'd203, 1'b1, 8'd0);
        send_tick(8'd1,   1'b1, 8'd1);
        send_tick(8'd255, 1'b1, 8'd255);
        send_tick(8'd255, 1'b1, 8'd2);
        send_tick(8'd255, 1'b0, 8'd2);
        send_tick(8'd0,   1'b0, 8'd0);
        send_tick(8'd0,   1'b1, 8'd0);
        send_tick(8'd170, 1'b1, 8'hAA);
        send_tick(8'd85,  1'b1, 8'h55);
        send_tick(8'd255, 1'b1, 8'd153);
        drain();

        // Random phases, each with its own idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            repeat (RANDOM_PER_PHASE)
                send_random_tick();
            drain();
        end

        // Add a few more ticks while fewer than two frames have reached blanking
        while (frames_seen < 2 && extra < EXTRA_LIMIT)
        begin
            send_random_tick();
            extra++;
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d ticks driven over four idling mixes, %0d results checked",
                 ticks_sent, results_checked);
        $display("%0d vertical blank entries and %0d render requests predicted",
                 frames_seen, renders_seen);
        if (fail_count == 0)
            $display("lcd_line_timing_and_mode_unit verification clean");
        else
            $display("lcd_line_timing_and_mode_unit verification failed");
        $finish;
    end

endmodule
